/* rtl/core/tfcd_pkg.sv */
package tfcd_pkg;

    localparam int FRAME_DEPTH_DEF = 32;
    localparam int HDR_DEPTH       = 6;
    localparam int LEN_W           = 6;
    localparam int LEN_MAX         = 63;

    localparam logic [7:0]  END_MARKER_RST = 8'hFF;
    localparam logic [2:0]  END_RUN_RST    = 3'd3;
    localparam logic [31:0] ONE_MHZ        = 32'd1000000;

    localparam logic [7:0] KIND_DATA = 8'h00;
    localparam logic [7:0] KIND_CTRL = 8'h01;

    localparam logic [7:0] SUB_FREQ    = 8'h00;
    localparam logic [7:0] SUB_AMP     = 8'h01;
    localparam logic [7:0] SUB_INIT    = 8'h00;
    localparam logic [7:0] SUB_SET_F   = 8'h01;
    localparam logic [7:0] SUB_SET_A   = 8'h02;
    localparam logic [7:0] SUB_SCAN_GO = 8'h03;
    localparam logic [7:0] SUB_SCAN_NO = 8'h04;
    localparam logic [7:0] SUB_CONNECT = 8'hAA;

    localparam logic CFG_END_MARKER = 1'b0;
    localparam logic CFG_END_RUN    = 1'b1;

    typedef enum logic [3:0] {
        ACT_FREQ_STORED = 4'd0,
        ACT_AMP_STORED  = 4'd1,
        ACT_INIT        = 4'd2,
        ACT_SET_FREQ    = 4'd3,
        ACT_SET_AMP     = 4'd4,
        ACT_SCAN_START  = 4'd5,
        ACT_SCAN_STOP   = 4'd6,
        ACT_CONNECT     = 4'd7,
        ACT_IGNORED     = 4'd8
    } action_t;

    typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

    typedef struct packed {
        logic        valid;
        action_t     action;
        logic [31:0] value;
        logic        freq_we;
        logic        amp_we;
        logic        connect;
    } dec_t;

endpackage

/* rtl/core/tfcd_decode.sv */
module tfcd_decode (
    input  tfcd_pkg::hdr_t hdr,
    input  logic [31:0]    freq_word,
    input  logic [23:0]    amp_word,
    input  logic           connected,
    output tfcd_pkg::dec_t dec
);

    logic [31:0] scan_base;
    logic [31:0] scan_hz;

    assign scan_base = {23'd0, ({1'b0, hdr[2]} + 9'd1)};
    assign scan_hz   = scan_base * tfcd_pkg::ONE_MHZ;

    always_comb begin
        dec         = '0;
        dec.action  = tfcd_pkg::ACT_FREQ_STORED;
        unique case (hdr[0])
            tfcd_pkg::KIND_DATA: begin
                if (hdr[1] == tfcd_pkg::SUB_FREQ) begin
                    dec.valid   = 1'b1;
                    dec.freq_we = 1'b1;
                    dec.action  = tfcd_pkg::ACT_FREQ_STORED;
                end else if (hdr[1] == tfcd_pkg::SUB_AMP) begin
                    dec.valid  = 1'b1;
                    dec.amp_we = 1'b1;
                    dec.action = tfcd_pkg::ACT_AMP_STORED;
                end
            end
            tfcd_pkg::KIND_CTRL: begin
                unique case (hdr[1])
                    tfcd_pkg::SUB_INIT: begin
                        dec.valid  = 1'b1;
                        dec.action = tfcd_pkg::ACT_INIT;
                    end
                    tfcd_pkg::SUB_CONNECT: begin
                        dec.valid   = 1'b1;
                        dec.connect = 1'b1;
                        dec.action  = tfcd_pkg::ACT_CONNECT;
                        dec.value   = tfcd_pkg::ONE_MHZ;
                    end
                    tfcd_pkg::SUB_SET_F: begin
                        dec.valid  = 1'b1;
                        dec.action = connected ? tfcd_pkg::ACT_SET_FREQ : tfcd_pkg::ACT_IGNORED;
                        dec.value  = connected ? freq_word : 32'd0;
                    end
                    tfcd_pkg::SUB_SET_A: begin
                        dec.valid  = 1'b1;
                        dec.action = connected ? tfcd_pkg::ACT_SET_AMP : tfcd_pkg::ACT_IGNORED;
                        dec.value  = connected ? {8'd0, amp_word} : 32'd0;
                    end
                    tfcd_pkg::SUB_SCAN_GO: begin
                        dec.valid  = 1'b1;
                        dec.action = connected ? tfcd_pkg::ACT_SCAN_START
                                               : tfcd_pkg::ACT_IGNORED;
                        dec.value  = connected ? scan_hz : 32'd0;
                    end
                    tfcd_pkg::SUB_SCAN_NO: begin
                        dec.valid  = 1'b1;
                        dec.action = connected ? tfcd_pkg::ACT_SCAN_STOP
                                               : tfcd_pkg::ACT_IGNORED;
                    end
                    default: begin
                        dec.valid = 1'b0;
                    end
                endcase
            end
            default: begin
                dec.valid = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/terminated_frame_command_decoder.sv */
// Channel  | Dir | Handshake           | Payload
// s_       | in  | s_tvalid / s_tready | s_tdata[7:0] rx_byte
// m_       | out | m_tvalid / m_tready | m_tdata action, value, frame_length
// cfg_     | in  | cfg_we              | cfg_addr index, cfg_wdata value
// One request per cycle while m_ is not stalled; data passes the input register, then the result register.
// The result register and the frame state update in the same cycle as the decode.
// A stalled m_ side holds the result; s_ keeps accepting while the input stage is free.
// Synchronous active-low reset clears frame state and both valid flags and loads the cfg_ defaults.
module terminated_frame_command_decoder #(
    parameter int FRAME_DEPTH = tfcd_pkg::FRAME_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] action, [35:4] value, [41:36] frame_length
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    localparam int LenCapInt = (FRAME_DEPTH < tfcd_pkg::LEN_MAX) ? FRAME_DEPTH
                                                                  : tfcd_pkg::LEN_MAX;
    localparam logic [tfcd_pkg::LEN_W-1:0] LenCap = tfcd_pkg::LEN_W'(LenCapInt);

    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic [7:0]                  end_marker_reg;
    logic [2:0]                  end_run_reg;
    tfcd_pkg::hdr_t              hdr_reg, hdr_next;
    logic [tfcd_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [2:0]                  run_reg, run_inc;
    logic [31:0]                 freq_reg;
    logic [23:0]                 amp_reg;
    logic                        connected_reg;
    logic                        m_valid_reg;
    logic [47:0]                 m_data_reg;

    logic        advance;
    logic        step;
    logic        hit;
    logic        close;
    logic [2:0]  need;
    tfcd_pkg::dec_t dec;

    assign advance  = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign hit     = (in_byte_reg == end_marker_reg);
    assign need    = (end_run_reg == 3'd0) ? 3'd1 : end_run_reg;
    assign run_inc = (run_reg == 3'd7) ? 3'd7 : run_reg + 3'd1;
    assign close   = hit && (run_inc >= need);

    always_comb begin
        hdr_next   = hdr_reg;
        count_next = count_reg;
        if (count_reg < LenCap) begin
            count_next = count_reg + tfcd_pkg::LEN_W'(1);
        end
        for (int i = 0; i < tfcd_pkg::HDR_DEPTH; i++) begin
            if (count_reg == tfcd_pkg::LEN_W'(i)) begin
                hdr_next[i] = in_byte_reg;
            end
        end
    end

    tfcd_decode u_decode (
        .hdr       (hdr_next),
        .freq_word (freq_reg),
        .amp_word  (amp_reg),
        .connected (connected_reg),
        .dec       (dec)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_marker_reg <= tfcd_pkg::END_MARKER_RST;
            end_run_reg    <= tfcd_pkg::END_RUN_RST;
        end else if (cfg_we) begin
            if (cfg_addr == tfcd_pkg::CFG_END_MARKER) begin
                end_marker_reg <= cfg_wdata;
            end else begin
                end_run_reg <= cfg_wdata[2:0];
            end
        end
    end

    // frame state: advance one byte per step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg       <= '0;
            count_reg     <= '0;
            run_reg       <= '0;
            freq_reg      <= '0;
            amp_reg       <= '0;
            connected_reg <= 1'b0;
        end else if (step) begin
            hdr_reg <= hdr_next;
            if (close) begin
                count_reg <= '0;
                run_reg   <= '0;
                if (dec.freq_we) begin
                    freq_reg <= {hdr_next[2], hdr_next[3], hdr_next[4], hdr_next[5]};
                end
                if (dec.amp_we) begin
                    amp_reg <= {hdr_next[2], hdr_next[3], hdr_next[4]};
                end
                if (dec.connect) begin
                    connected_reg <= 1'b1;
                end
            end else begin
                count_reg <= count_next;
                run_reg   <= hit ? run_inc : 3'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= step && close && dec.valid;
        end
        if (step && close && dec.valid) begin
            m_data_reg <= {6'd0, count_next, dec.value, dec.action};
        end
    end

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LenCap)
        else $error("frame byte count exceeds cap");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(step) && $past(close))
        else $error("result appeared without a closing byte");

    a_close_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && close |=> count_reg == '0 && run_reg == 3'd0)
        else $error("frame state not cleared after close");

    a_connect_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $past(connected_reg) |-> connected_reg)
        else $error("connection dropped without reset");

endmodule
